>>> sv/hse_pkg.sv
// Shared types, codes and SHA-512 constants for the key expander.
`timescale 1ns / 1ps
`default_nettype none
package hse_pkg;

    localparam logic [1:0] OP_SECRET = 2'd0;
    localparam logic [1:0] OP_SEED   = 2'd1;
    localparam logic [1:0] OP_GEN    = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_EMPTY    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    localparam logic [1:0] HS_KEY   = 2'd0;
    localparam logic [1:0] HS_INNER = 2'd1;
    localparam logic [1:0] HS_OUTER = 2'd2;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;
    localparam int DIGEST = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_FILL,
        ST_RND,
        ST_FIN,
        ST_HDONE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       wr_secret;
        logic       wr_seed;
        logic       clr;
        logic       clr_chain;
        logic       init;
        logic       shift;
        logic       load_v;
        logic       round;
        logic       final_add;
        logic       capture;
        logic       emit;
        logic       err_emit;
        logic [1:0] hash_sel;
        logic       hmac_sel;
        logic [8:0] pos;
        logic [6:0] rnd;
        logic [2:0] word_idx;
        logic [3:0] vb;
        logic       last;
        logic [1:0] err;
    } cmd_t;

    typedef struct packed {
        logic       ovf;
        logic       secret_empty;
        logic       seed_empty;
        logic [8:0] n;
        logic [1:0] last_blk;
        logic       out_free;
    } status_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] bsig0(input logic [63:0] x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] bsig1(input logic [63:0] x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] ssig0(input logic [63:0] x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] ssig1(input logic [63:0] x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] hinit(input logic [2:0] i);
        logic [63:0] r;
        case (i)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] kround(input logic [6:0] i);
        logic [63:0] r;
        case (i)
            7'd0:  r = 64'h428a2f98d728ae22;
            7'd1:  r = 64'h7137449123ef65cd;
            7'd2:  r = 64'hb5c0fbcfec4d3b2f;
            7'd3:  r = 64'he9b5dba58189dbbc;
            7'd4:  r = 64'h3956c25bf348b538;
            7'd5:  r = 64'h59f111f1b605d019;
            7'd6:  r = 64'h923f82a4af194f9b;
            7'd7:  r = 64'hab1c5ed5da6d8118;
            7'd8:  r = 64'hd807aa98a3030242;
            7'd9:  r = 64'h12835b0145706fbe;
            7'd10: r = 64'h243185be4ee4b28c;
            7'd11: r = 64'h550c7dc3d5ffb4e2;
            7'd12: r = 64'h72be5d74f27b896f;
            7'd13: r = 64'h80deb1fe3b1696b1;
            7'd14: r = 64'h9bdc06a725c71235;
            7'd15: r = 64'hc19bf174cf692694;
            7'd16: r = 64'he49b69c19ef14ad2;
            7'd17: r = 64'hefbe4786384f25e3;
            7'd18: r = 64'h0fc19dc68b8cd5b5;
            7'd19: r = 64'h240ca1cc77ac9c65;
            7'd20: r = 64'h2de92c6f592b0275;
            7'd21: r = 64'h4a7484aa6ea6e483;
            7'd22: r = 64'h5cb0a9dcbd41fbd4;
            7'd23: r = 64'h76f988da831153b5;
            7'd24: r = 64'h983e5152ee66dfab;
            7'd25: r = 64'ha831c66d2db43210;
            7'd26: r = 64'hb00327c898fb213f;
            7'd27: r = 64'hbf597fc7beef0ee4;
            7'd28: r = 64'hc6e00bf33da88fc2;
            7'd29: r = 64'hd5a79147930aa725;
            7'd30: r = 64'h06ca6351e003826f;
            7'd31: r = 64'h142929670a0e6e70;
            7'd32: r = 64'h27b70a8546d22ffc;
            7'd33: r = 64'h2e1b21385c26c926;
            7'd34: r = 64'h4d2c6dfc5ac42aed;
            7'd35: r = 64'h53380d139d95b3df;
            7'd36: r = 64'h650a73548baf63de;
            7'd37: r = 64'h766a0abb3c77b2a8;
            7'd38: r = 64'h81c2c92e47edaee6;
            7'd39: r = 64'h92722c851482353b;
            7'd40: r = 64'ha2bfe8a14cf10364;
            7'd41: r = 64'ha81a664bbc423001;
            7'd42: r = 64'hc24b8b70d0f89791;
            7'd43: r = 64'hc76c51a30654be30;
            7'd44: r = 64'hd192e819d6ef5218;
            7'd45: r = 64'hd69906245565a910;
            7'd46: r = 64'hf40e35855771202a;
            7'd47: r = 64'h106aa07032bbd1b8;
            7'd48: r = 64'h19a4c116b8d2d0c8;
            7'd49: r = 64'h1e376c085141ab53;
            7'd50: r = 64'h2748774cdf8eeb99;
            7'd51: r = 64'h34b0bcb5e19b48a8;
            7'd52: r = 64'h391c0cb3c5c95a63;
            7'd53: r = 64'h4ed8aa4ae3418acb;
            7'd54: r = 64'h5b9cca4f7763e373;
            7'd55: r = 64'h682e6ff3d6b2b8a3;
            7'd56: r = 64'h748f82ee5defb2fc;
            7'd57: r = 64'h78a5636f43172f60;
            7'd58: r = 64'h84c87814a1f0ab72;
            7'd59: r = 64'h8cc702081a6439ec;
            7'd60: r = 64'h90befffa23631e28;
            7'd61: r = 64'ha4506cebde82bde9;
            7'd62: r = 64'hbef9a3f7b2c67915;
            7'd63: r = 64'hc67178f2e372532b;
            7'd64: r = 64'hca273eceea26619c;
            7'd65: r = 64'hd186b8c721c0c207;
            7'd66: r = 64'heada7dd6cde0eb1e;
            7'd67: r = 64'hf57d4f7fee6ed178;
            7'd68: r = 64'h06f067aa72176fba;
            7'd69: r = 64'h0a637dc5a2c898a6;
            7'd70: r = 64'h113f9804bef90dae;
            7'd71: r = 64'h1b710b35131c471b;
            7'd72: r = 64'h28db77f523047d84;
            7'd73: r = 64'h32caab7b40c72493;
            7'd74: r = 64'h3c9ebe0a15c9bebc;
            7'd75: r = 64'h431d67c49c100d4c;
            7'd76: r = 64'h4cc5d4becb3e42b6;
            7'd77: r = 64'h597f299cfc657e2a;
            7'd78: r = 64'h5fcb6fab3ad6faec;
            7'd79: r = 64'h6c44198c4a475817;
            default: r = 64'h0;
        endcase
        return r;
    endfunction

    // Byte i of a 64-byte digest, byte 0 in the top bits.
    function automatic logic [7:0] dbyte(input logic [511:0] d, input logic [5:0] i);
        return d[511 - 8 * i -: 8];
    endfunction

endpackage
`default_nettype wire

>>> sv/hse_dp.sv
// Datapath: byte stores, message byte source, SHA-512 round unit and output register.
`timescale 1ns / 1ps
`default_nettype none
module hse_dp
    import hse_pkg::*;
#(
    parameter int MAX_SECRET = 128,
    parameter int MAX_SEED   = 64,
    parameter int MAX_OUT    = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output status_t          st,
    input  wire logic [7:0]  in_byte,
    input  wire logic        cfg_valid,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic [71:0]      m_tdata,
    output logic             m_tlast,
    output logic [1:0]       m_tuser
);

    localparam int SAW = (MAX_SECRET > 1) ? $clog2(MAX_SECRET) : 1;
    localparam int DAW = (MAX_SEED > 1) ? $clog2(MAX_SEED) : 1;

    logic [7:0]  secret_mem [MAX_SECRET];
    logic [7:0]  seed_mem [MAX_SEED];
    logic [7:0]  secret_rd_reg;
    logic [7:0]  seed_rd_reg;
    logic [7:0]  secret_len_reg;
    logic [6:0]  seed_len_reg;
    logic        ovf_reg;
    logic [8:0]  out_len_reg;

    logic [63:0] h_reg [8];
    logic [63:0] v_reg [8];
    logic [63:0] w_reg [16];
    logic [511:0] kp_reg;
    logic [511:0] inner_reg;
    logic [511:0] chain_reg;
    logic [511:0] h_flat;

    logic        out_valid_reg;
    logic [63:0] out_word_reg;
    logic [3:0]  out_vb_reg;
    logic        out_last_reg;
    logic [1:0]  out_err_reg;

    logic        secret_room;
    logic        seed_room;
    logic [8:0]  body_idx;
    logic [8:0]  msg_len;
    logic [9:0]  lb_sum;
    logic [11:0] len_bits;
    logic [7:0]  pre_byte;
    logic [7:0]  body_byte;
    logic [7:0]  msg_byte;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] w_new;
    logic [63:0] emit_mask;

    assign secret_room = secret_len_reg < 8'(MAX_SECRET);
    assign seed_room   = {1'b0, seed_len_reg} < 8'(MAX_SEED);
    assign body_idx    = cmd.pos - 9'd64;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            h_flat[511 - 64 * i -: 64] = h_reg[i];
        end
    end

    // Stores: written on load transfers, read every cycle with a registered port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_secret && secret_room)
        begin
            secret_mem[secret_len_reg[SAW-1:0]] <= in_byte;
        end
        secret_rd_reg <= secret_mem[body_idx[SAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_seed && seed_room)
        begin
            seed_mem[seed_len_reg[DAW-1:0]] <= in_byte;
        end
        seed_rd_reg <= seed_mem[body_idx[DAW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secret_len_reg <= '0;
            seed_len_reg   <= '0;
            ovf_reg        <= 1'b0;
            out_len_reg    <= 9'd64;
        end
        else
        begin
            if (cfg_valid)
            begin
                out_len_reg <= cfg_data;
            end
            if (cmd.clr)
            begin
                secret_len_reg <= '0;
                seed_len_reg   <= '0;
                ovf_reg        <= 1'b0;
            end
            else if (cmd.wr_secret)
            begin
                if (secret_room)
                begin
                    secret_len_reg <= secret_len_reg + 8'd1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            else if (cmd.wr_seed)
            begin
                if (seed_room)
                begin
                    seed_len_reg <= seed_len_reg + 7'd1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // Message byte at the current position of the running hash
    always_comb
    begin
        case (cmd.hash_sel)
            HS_KEY:
            begin
                msg_len   = 9'd64 + {2'b0, seed_len_reg};
                pre_byte  = dbyte(chain_reg, cmd.pos[5:0]);
                body_byte = seed_rd_reg;
            end
            HS_INNER:
            begin
                msg_len   = 9'd64 + {1'b0, secret_len_reg};
                pre_byte  = dbyte(kp_reg, cmd.pos[5:0]) ^ IPAD;
                body_byte = secret_rd_reg;
            end
            default:
            begin
                msg_len   = 9'd128;
                pre_byte  = dbyte(kp_reg, cmd.pos[5:0]) ^ OPAD;
                body_byte = dbyte(inner_reg, body_idx[5:0]);
            end
        endcase
        lb_sum   = {1'b0, msg_len} + 10'd16;
        len_bits = {msg_len, 3'b0};
        if (cmd.pos < 9'd64)
        begin
            msg_byte = pre_byte;
        end
        else if (cmd.pos < msg_len)
        begin
            msg_byte = body_byte;
        end
        else if (cmd.pos == msg_len)
        begin
            msg_byte = 8'h80;
        end
        else if (cmd.pos[8:7] == lb_sum[8:7] && cmd.pos[6:0] == 7'd126)
        begin
            msg_byte = {4'b0, len_bits[11:8]};
        end
        else if (cmd.pos[8:7] == lb_sum[8:7] && cmd.pos[6:0] == 7'd127)
        begin
            msg_byte = len_bits[7:0];
        end
        else
        begin
            msg_byte = 8'h00;
        end
    end

    assign t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + kround(cmd.rnd) + w_reg[0];
    assign t2 = bsig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign w_new = w_reg[0] + ssig0(w_reg[1]) + w_reg[9] + ssig1(w_reg[14]);

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= {w_reg[i][55:0], w_reg[i+1][63:56]};
            end
            w_reg[15] <= {w_reg[15][55:0], msg_byte};
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_v)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.round)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= hinit(3'(i));
            end
        end
        else if (cmd.final_add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    // Hold each finished digest where the next hash will read it
    always_ff @(posedge clk)
    begin
        if (cmd.clr_chain)
        begin
            chain_reg <= '0;
        end
        else if (cmd.capture && cmd.hash_sel == HS_OUTER && !cmd.hmac_sel)
        begin
            chain_reg <= h_flat;
        end
        if (cmd.capture && cmd.hash_sel == HS_KEY)
        begin
            kp_reg <= h_flat;
        end
        if (cmd.capture && cmd.hash_sel == HS_INNER)
        begin
            inner_reg <= h_flat;
        end
    end

    assign emit_mask = ~({64{1'b1}} >> {cmd.vb, 3'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.err_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit || cmd.err_emit)
        begin
            out_word_reg <= cmd.emit ? (h_reg[cmd.word_idx] & emit_mask) : 64'h0;
            out_vb_reg   <= cmd.vb;
            out_last_reg <= cmd.last;
            out_err_reg  <= cmd.err;
        end
    end

    always_comb
    begin
        st.ovf          = ovf_reg;
        st.secret_empty = secret_len_reg == 8'd0;
        st.seed_empty   = seed_len_reg == 7'd0;
        st.n            = (out_len_reg > 9'(MAX_OUT)) ? 9'(MAX_OUT) : out_len_reg;
        st.last_blk     = lb_sum[8:7];
        st.out_free     = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_vb_reg, out_word_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule
`default_nettype wire

>>> sv/hse_ctrl.sv
// Controller: sequences byte loads, hash blocks, rounds and result transfers.
`timescale 1ns / 1ps
`default_nettype none
module hse_ctrl
    import hse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [1:0] s_tuser,
    input  wire status_t    st,
    output cmd_t            cmd
);

    state_t      state_reg, state_next;
    logic [1:0]  blk_reg, blk_next;
    logic [6:0]  fill_reg, fill_next;
    logic        phase_reg, phase_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [1:0]  hash_reg, hash_next;
    logic        hmac_reg, hmac_next;
    logic [8:0]  rem_reg, rem_next;
    logic [2:0]  word_reg, word_next;
    logic [1:0]  err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            blk_reg   <= '0;
            fill_reg  <= '0;
            phase_reg <= 1'b0;
            rnd_reg   <= '0;
            hash_reg  <= HS_KEY;
            hmac_reg  <= 1'b0;
            rem_reg   <= '0;
            word_reg  <= '0;
            err_reg   <= ERR_OK;
        end
        else
        begin
            state_reg <= state_next;
            blk_reg   <= blk_next;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            rnd_reg   <= rnd_next;
            hash_reg  <= hash_next;
            hmac_reg  <= hmac_next;
            rem_reg   <= rem_next;
            word_reg  <= word_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        blk_next   = blk_reg;
        fill_next  = fill_reg;
        phase_next = phase_reg;
        rnd_next   = rnd_reg;
        hash_next  = hash_reg;
        hmac_next  = hmac_reg;
        rem_next   = rem_reg;
        word_next  = word_reg;
        err_next   = err_reg;
        s_tready   = 1'b0;

        cmd           = '0;
        cmd.hash_sel  = hash_reg;
        cmd.hmac_sel  = hmac_reg;
        cmd.pos       = {blk_reg, fill_reg};
        cmd.rnd       = rnd_reg;
        cmd.word_idx  = word_reg;
        cmd.vb        = (rem_reg >= 9'd8) ? 4'd8 : rem_reg[3:0];
        cmd.last      = rem_reg <= 9'd8;
        cmd.err       = ERR_OK;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (s_tuser)
                        OP_SECRET: cmd.wr_secret = 1'b1;
                        OP_SEED:   cmd.wr_seed = 1'b1;
                        OP_CLEAR:  cmd.clr = 1'b1;
                        default:
                        begin
                            cmd.clr_chain = 1'b1;
                            if (st.ovf)
                            begin
                                err_next   = ERR_OVERFLOW;
                                state_next = ST_ERR;
                            end
                            else if (st.secret_empty || st.seed_empty)
                            begin
                                err_next   = ERR_EMPTY;
                                state_next = ST_ERR;
                            end
                            else if (st.n == 9'd0)
                            begin
                                err_next   = ERR_OK;
                                state_next = ST_ERR;
                            end
                            else
                            begin
                                rem_next   = st.n;
                                hmac_next  = 1'b0;
                                hash_next  = HS_KEY;
                                cmd.init   = 1'b1;
                                blk_next   = '0;
                                fill_next  = '0;
                                phase_next = 1'b0;
                                state_next = ST_FILL;
                            end
                        end
                    endcase
                end
            end
            ST_ERR:
            begin
                if (st.out_free)
                begin
                    cmd.err_emit = 1'b1;
                    cmd.vb       = 4'd0;
                    cmd.last     = 1'b1;
                    cmd.err      = err_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                // phase 0 fetches from the stores, phase 1 shifts the byte in
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    cmd.shift  = 1'b1;
                    phase_next = 1'b0;
                    fill_next  = fill_reg + 7'd1;
                    if (fill_reg == 7'd127)
                    begin
                        cmd.load_v = 1'b1;
                        rnd_next   = '0;
                        state_next = ST_RND;
                    end
                end
            end
            ST_RND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == 7'd79)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.final_add = 1'b1;
                if (blk_reg == st.last_blk)
                begin
                    state_next = ST_HDONE;
                end
                else
                begin
                    blk_next   = blk_reg + 2'd1;
                    state_next = ST_FILL;
                end
            end
            ST_HDONE:
            begin
                cmd.capture = 1'b1;
                blk_next    = '0;
                fill_next   = '0;
                phase_next  = 1'b0;
                if (hash_reg == HS_KEY)
                begin
                    hash_next  = HS_INNER;
                    cmd.init   = 1'b1;
                    state_next = ST_FILL;
                end
                else if (hash_reg == HS_INNER)
                begin
                    hash_next  = HS_OUTER;
                    cmd.init   = 1'b1;
                    state_next = ST_FILL;
                end
                else if (!hmac_reg)
                begin
                    hmac_next  = 1'b1;
                    hash_next  = HS_KEY;
                    cmd.init   = 1'b1;
                    state_next = ST_FILL;
                end
                else
                begin
                    word_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit  = 1'b1;
                    rem_next  = rem_reg - {5'b0, cmd.vb};
                    word_next = word_reg + 3'd1;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (word_reg == 3'd7)
                    begin
                        // next 64-byte block: advance the chain value first
                        hmac_next  = 1'b0;
                        hash_next  = HS_KEY;
                        cmd.init   = 1'b1;
                        blk_next   = '0;
                        fill_next  = '0;
                        phase_next = 1'b0;
                        state_next = ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/hmac_sha512_key_expander_unit.sv
// Top level of the HMAC-SHA-512 key expander: controller and datapath.
// Loads and clears give no result.
// A SHA-512 block is a byte fill (fetch, then shift, per byte; one store read port), 80 rounds, 1 add.
// An HMAC is 4 to 6 blocks; each 64 output bytes need two HMACs,
// then one transfer per 8-byte word. One generate at a time.
// Asynchronous active-low reset empties both stores, clears overflow and sets out_len to 64.
`timescale 1ns / 1ps
`default_nettype none
module hmac_sha512_key_expander_unit
    import hse_pkg::*;
#(
    parameter int MAX_SECRET = 128,
    parameter int MAX_SEED   = 64,
    parameter int MAX_OUT    = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,    // [1:0] opcode
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,    // [63:0] out_word, [67:64] valid_bytes, rest zero
    output logic             m_tlast,
    output logic [1:0]       m_tuser     // [1:0] error_code
);

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    hse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .st       (st),
        .cmd      (cmd)
    );

    hse_dp #(
        .MAX_SECRET (MAX_SECRET),
        .MAX_SEED   (MAX_SEED),
        .MAX_OUT    (MAX_OUT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_byte   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

>>> bench/tb_hmac_sha512_key_expander_unit.sv
// Self-checking testbench for the HMAC-SHA-512 key expander with a built-in predictor.
`timescale 1ns / 1ps
module tb_hmac_sha512_key_expander_unit;
    import hse_pkg::*;

    localparam int SECRET_CAP = 128;
    localparam int SEED_CAP   = 64;
    localparam int OUT_CAP    = 256;
    localparam int SETTLE     = 16;
    localparam int STALL_MAX  = 60000;
    localparam int HOLD_LEN   = 3000;
    localparam int QUIET_LO   = 30000;
    localparam int QUIET_HI   = 80000;

    localparam logic [63:0] IV512 [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] K512 [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    typedef enum logic [1:0] { ACT_XFER, ACT_DRAIN, ACT_CFG } act_t;

    typedef struct {
        act_t       kind;
        logic [1:0] op;
        logic [7:0] data;
        logic [8:0] len;
    } step_t;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  vb;
        logic        last;
        logic [1:0]  err;
    } key_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] data_byte
    logic [1:0]  s_tuser = '0;      // [1:0] opcode
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;           // [63:0] out_word, [67:64] valid_bytes
    logic        m_tlast;
    logic [1:0]  m_tuser;           // [1:0] error_code

    hmac_sha512_key_expander_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [7:0] secret_mem [0:SECRET_CAP-1];
    logic [7:0] seed_mem [0:SEED_CAP-1];
    int         secret_len = 0;
    int         seed_len = 0;
    logic       ovf_seen = 1'b0;
    logic [8:0] key_len = 9'd64;
    logic [7:0] msg_buf [0:255];

    step_t     pending_q [$];
    key_word_t key_words_q [$];
    int        bad_cnt = 0;
    int        words_seen = 0;
    int        items_queued = 0;
    int        cyc = 0;
    int        quiet_cnt = 0;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // SHA-512 over msg_buf[0 .. len-1]
    function automatic logic [511:0] sha512_digest(input int len);
        logic [7:0]  p [0:383];
        logic [63:0] h [0:7];
        logic [63:0] v [0:7];
        logic [63:0] w [0:79];
        logic [63:0] t1, t2, s0, s1, bits;
        int nb;
        for (int i = 0; i < 384; i++) p[i] = (i < len) ? msg_buf[i] : 8'h00;
        p[len] = 8'h80;
        nb = (len + 144) / 128;
        bits = 64'(len) * 8;
        for (int b = 0; b < 8; b++) p[nb * 128 - 1 - b] = bits[8 * b +: 8];
        for (int i = 0; i < 8; i++) h[i] = IV512[i];
        for (int blk = 0; blk < nb; blk++)
        begin
            for (int i = 0; i < 16; i++)
                for (int b = 0; b < 8; b++) w[i][63 - 8 * b -: 8] = p[blk * 128 + i * 8 + b];
            for (int i = 16; i < 80; i++)
            begin
                s0 = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
                s1 = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            for (int i = 0; i < 8; i++) v[i] = h[i];
            for (int i = 0; i < 80; i++)
            begin
                t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K512[i] + w[i];
                t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
        end
        return {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
    endfunction

    // HMAC keyed by chain || seed over the secret; the key is always hashed first
    function automatic logic [511:0] prf_hmac(input logic [511:0] chain);
        logic [511:0] kp, inner;
        for (int i = 0; i < 64; i++) msg_buf[i] = chain[511 - 8 * i -: 8];
        for (int i = 0; i < seed_len; i++) msg_buf[64 + i] = seed_mem[i];
        kp = sha512_digest(64 + seed_len);
        for (int i = 0; i < 64; i++) msg_buf[i] = kp[511 - 8 * i -: 8] ^ 8'h36;
        for (int i = 0; i < secret_len; i++) msg_buf[64 + i] = secret_mem[i];
        inner = sha512_digest(64 + secret_len);
        for (int i = 0; i < 64; i++)
        begin
            msg_buf[i] = kp[511 - 8 * i -: 8] ^ 8'h5c;
            msg_buf[64 + i] = inner[511 - 8 * i -: 8];
        end
        return sha512_digest(128);
    endfunction

    function automatic void add_key_word(logic [63:0] word, logic [3:0] vb, logic last,
                                         logic [1:0] err);
        key_word_t e;
        e.word = word; e.vb = vb; e.last = last; e.err = err;
        key_words_q.push_back(e);
    endfunction

    function automatic void expand_key();
        logic [511:0] chain, blk;
        logic [7:0]   mat [0:OUT_CAP-1];
        logic [63:0]  w;
        int n, vb;
        if (ovf_seen)
            add_key_word('0, 4'd0, 1'b1, ERR_OVERFLOW);
        else if (secret_len == 0 || seed_len == 0)
            add_key_word('0, 4'd0, 1'b1, ERR_EMPTY);
        else
        begin
            n = (key_len > OUT_CAP) ? OUT_CAP : key_len;
            if (n == 0)
                add_key_word('0, 4'd0, 1'b1, ERR_OK);
            else
            begin
                chain = '0;
                for (int done = 0; done < n; done += 64)
                begin
                    chain = prf_hmac(chain);
                    blk = prf_hmac(chain);
                    for (int i = 0; i < 64; i++)
                        if (done + i < OUT_CAP) mat[done + i] = blk[511 - 8 * i -: 8];
                end
                for (int done = 0; done < n; done += 8)
                begin
                    vb = (n - done < 8) ? n - done : 8;
                    w = '0;
                    for (int i = 0; i < 8; i++)
                        if (i < vb) w[63 - 8 * i -: 8] = mat[done + i];
                    add_key_word(w, 4'(vb), (done + vb == n), ERR_OK);
                end
            end
        end
    endfunction

    function automatic void absorb_op(logic [1:0] op, logic [7:0] data);
        case (op)
            OP_SECRET:
                if (secret_len < SECRET_CAP) secret_mem[secret_len++] = data;
                else ovf_seen = 1'b1;
            OP_SEED:
                if (seed_len < SEED_CAP) seed_mem[seed_len++] = data;
                else ovf_seen = 1'b1;
            OP_CLEAR:
            begin
                secret_len = 0;
                seed_len = 0;
                ovf_seen = 1'b0;
            end
            default: expand_key();
        endcase
    endfunction

    function automatic logic idle_roll();
        return (cyc < QUIET_LO || cyc >= QUIET_HI) && ($urandom_range(0, 99) < 25);
    endfunction

    always @(posedge clk) cyc <= cyc + 1;

    // driver
    step_t head;
    logic  drv_busy, cfg_busy;
    int    settle_cnt = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            drv_busy = s_tvalid;
            cfg_busy = cfg_valid;
            if (s_tvalid && s_tready)
            begin
                absorb_op(s_tuser, s_tdata);
                drv_busy = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                key_len = cfg_data;
                cfg_busy = 1'b0;
            end
            if (!drv_busy && !cfg_busy && pending_q.size() > 0)
            begin
                head = pending_q[0];
                if (head.kind == ACT_XFER)
                begin
                    if (!idle_roll())
                    begin
                        void'(pending_q.pop_front());
                        s_tuser <= head.op;
                        s_tdata <= head.data;
                        drv_busy = 1'b1;
                    end
                end
                // hold until every key word is back and the block has gone quiet
                else if (key_words_q.size() != 0)
                    settle_cnt = 0;
                else if (settle_cnt < SETTLE)
                    settle_cnt++;
                else
                begin
                    settle_cnt = 0;
                    void'(pending_q.pop_front());
                    if (head.kind == ACT_CFG)
                    begin
                        cfg_data <= head.len;
                        cfg_busy = 1'b1;
                    end
                end
            end
            s_tvalid <= drv_busy;
            cfg_valid <= cfg_busy;
        end
    end

    // monitor and checker
    key_word_t want;
    int        hold_cnt = 0;
    logic      hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                words_seen++;
                if (key_words_q.size() == 0)
                begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("unexpected key word: word=%h vb=%0d last=%0d err=%0d",
                                 m_tdata[63:0], m_tdata[67:64], m_tlast, m_tuser);
                end
                else
                begin
                    want = key_words_q.pop_front();
                    if (m_tdata[63:0] !== want.word || m_tdata[67:64] !== want.vb
                        || m_tlast !== want.last || m_tuser !== want.err)
                    begin
                        bad_cnt++;
                        if (bad_cnt <= 10)
                            $display("key word mismatch: exp word=%h vb=%0d last=%0d err=%0d",
                                     want.word, want.vb, want.last, want.err,
                                     " got word=%h vb=%0d last=%0d err=%0d",
                                     m_tdata[63:0], m_tdata[67:64], m_tlast, m_tuser);
                    end
                end
            end
            // back-pressure once for a long stretch so the input side stalls
            if (!hold_done && m_tvalid && words_seen >= 20)
            begin
                hold_done = 1'b1;
                hold_cnt = HOLD_LEN;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !idle_roll();
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_MAX)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_op(logic [1:0] op, logic [7:0] data);
        step_t s;
        s.kind = ACT_XFER; s.op = op; s.data = data; s.len = '0;
        pending_q.push_back(s);
        items_queued++;
    endtask

    task automatic queue_len(logic [8:0] len);
        step_t s;
        s.kind = ACT_CFG; s.op = OP_CLEAR; s.data = '0; s.len = len;
        pending_q.push_back(s);
    endtask

    task automatic queue_drain();
        step_t s;
        s.kind = ACT_DRAIN; s.op = OP_CLEAR; s.data = '0; s.len = '0;
        pending_q.push_back(s);
    endtask

    // one load-and-generate sequence; a count below zero picks a random size
    task automatic queue_session(int n_secret, int n_seed);
        int ns, nd, pick;
        ns = n_secret;
        nd = n_seed;
        if (ns < 0)
        begin
            pick = $urandom_range(0, 19);
            ns = (pick < 16) ? $urandom_range(1, 24) : (pick < 18) ? SECRET_CAP
               : (pick == 18) ? SECRET_CAP + 1 : 0;
        end
        if (nd < 0)
        begin
            pick = $urandom_range(0, 19);
            nd = (pick < 16) ? $urandom_range(1, 16) : (pick < 18) ? SEED_CAP
               : (pick == 18) ? SEED_CAP + 1 : 0;
        end
        queue_op(OP_CLEAR, 8'($urandom));
        while (ns + nd > 0)
        begin
            if (nd == 0 || (ns > 0 && $urandom_range(0, 1)))
            begin
                queue_op(OP_SECRET, 8'($urandom));
                ns--;
            end
            else
            begin
                queue_op(OP_SEED, 8'($urandom));
                nd--;
            end
            // noise: a stray generate in the middle of a load
            if ($urandom_range(0, 99) < 2) queue_op(OP_GEN, 8'($urandom));
        end
        repeat ($urandom_range(1, 2)) queue_op(OP_GEN, 8'($urandom));
    endtask

    logic [8:0] len_pick;

    initial
    begin
        // directed: empty buffers, single bytes, repeat generate, length extremes
        queue_op(OP_GEN, 8'h00);
        queue_op(OP_SECRET, 8'h00);
        queue_op(OP_GEN, 8'hff);
        queue_op(OP_SEED, 8'hff);
        queue_op(OP_SECRET, 8'hff);
        queue_op(OP_GEN, 8'h00);
        queue_op(OP_GEN, 8'h5a);
        queue_op(OP_CLEAR, 8'hff);
        queue_op(OP_GEN, 8'h00);
        queue_op(OP_SECRET, 8'h5a);
        queue_op(OP_SEED, 8'ha5);
        queue_len(9'd0);
        queue_op(OP_GEN, 8'h00);
        queue_len(9'd511);
        queue_op(OP_GEN, 8'h00);
        queue_len(9'd1);
        queue_op(OP_GEN, 8'h00);
        queue_len(9'd9);
        queue_op(OP_CLEAR, 8'h00);
        queue_op(OP_SEED, 8'h0f);
        queue_op(OP_GEN, 8'h00);
        queue_op(OP_SECRET, 8'hf0);
        queue_op(OP_GEN, 8'h00);

        // random: overflow on the seed first, then mixed sessions and lengths
        queue_session(3, SEED_CAP + 1);
        while (items_queued < 250)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 9))
                    0: len_pick = 9'd256;
                    1: len_pick = 9'($urandom_range(257, 511));
                    2: len_pick = 9'd0;
                    3: len_pick = 9'($urandom_range(65, 200));
                    default: len_pick = 9'($urandom_range(1, 64));
                endcase
                queue_len(len_pick);
            end
            queue_session(-1, -1);
            // let the pipeline run dry now and then
            if ($urandom_range(0, 4) == 0) queue_drain();
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk);
        while (pending_q.size() != 0 || s_tvalid || cfg_valid || key_words_q.size() != 0);
        repeat (100) @(posedge clk);

        if (bad_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
